>>> src/winding_resistance_check_core_defines.svh
// ----------------------------------------------------------------------------
// Winding resistance check assertion macros
// Shared macros for the concurrent assertions of the checker.
// ----------------------------------------------------------------------------
`ifndef WINDING_RESISTANCE_CHECK_CORE_DEFINES_SVH
`define WINDING_RESISTANCE_CHECK_CORE_DEFINES_SVH

// Clocked property that is disabled while reset is applied.
`define WRC_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define WRC_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> src/wrc_pkg.sv
// ----------------------------------------------------------------------------
// Winding resistance check package
// Widths, register indexes, alarm codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package wrc_pkg;

	localparam int SUPPLY_BITS = 12;
	localparam int DUTY_BITS   = 10;
	localparam int GAIN_W      = 32;
	localparam int OFFSET_W    = 31;
	localparam int LIMIT_W     = 10;
	localparam int PCT_W       = 7;
	localparam int R_W         = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CMP_W       = (DUTY_BITS > LIMIT_W) ? DUTY_BITS : LIMIT_W;

	localparam int SD_W   = SUPPLY_BITS + DUTY_BITS;
	localparam int PROD_W = SD_W + GAIN_W;
	localparam int LV_W   = PROD_W - 7;

	localparam int SUM_W = R_W + 2;
	localparam int D_W   = SUM_W + 1;
	localparam int LHS_W = D_W + 7;
	localparam int RHS_W = SUM_W + PCT_W;

	localparam logic [LHS_W-1:0] PCT_SCALE = LHS_W'(100);

	localparam logic signed [R_W-1:0] R_MAX = {1'b0, {(R_W-1){1'b1}}};
	localparam logic signed [R_W-1:0] R_MIN = {1'b1, {(R_W-1){1'b0}}};

	localparam logic [LIMIT_W-1:0] SHORT_LIM_RST = LIMIT_W'(20);
	localparam logic [LIMIT_W-1:0] OPEN_LIM_RST  = LIMIT_W'(350);
	localparam logic [PCT_W-1:0]   PCT_RST       = PCT_W'(10);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_GAIN    = 3'd0,
		REG_SENSE_OFFSET = 3'd1,
		REG_SHORT_LIMIT  = 3'd2,
		REG_OPEN_LIMIT   = 3'd3,
		REG_IMB_PERCENT  = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ALARM_NONE      = 2'd0,
		ALARM_LOW_DUTY  = 2'd1,
		ALARM_HIGH_DUTY = 2'd2,
		ALARM_IMBALANCE = 2'd3
	} alarm_t;

	typedef struct packed {
		logic [GAIN_W-1:0]   line_gain;
		logic [OFFSET_W-1:0] sense_offset;
		logic [LIMIT_W-1:0]  short_limit;
		logic [LIMIT_W-1:0]  open_limit;
		logic [PCT_W-1:0]    imb_percent;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic short_f;
		logic open_f;
	} ctl_t;

	function automatic logic signed [R_W-1:0] sat_half(input logic signed [SUM_W-1:0] a);
		logic signed [SUM_W-1:0] h;
		h = a >>> 1;
		if (h[SUM_W-1:R_W-1] == '0 || h[SUM_W-1:R_W-1] == '1) begin
			return h[R_W-1:0];
		end else begin
			return h[SUM_W-1] ? R_MIN : R_MAX;
		end
	endfunction

endpackage

`default_nettype wire

>>> src/wrc_cfg.sv
// ----------------------------------------------------------------------------
// Winding resistance check configuration registers
// Holds the gain, offset, duty limits and imbalance band.
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_cfg
	import wrc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  we,
	input  wire logic [CFG_IDX_W-1:0]  idx,
	input  wire logic [CFG_DATA_W-1:0] data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_gain    <= '0;
			cfg_q.sense_offset <= '0;
			cfg_q.short_limit  <= SHORT_LIM_RST;
			cfg_q.open_limit   <= OPEN_LIM_RST;
			cfg_q.imb_percent  <= PCT_RST;
		end else if (we) begin
			unique case (cfg_idx_t'(idx))
				REG_LINE_GAIN:    cfg_q.line_gain    <= data[GAIN_W-1:0];
				REG_SENSE_OFFSET: cfg_q.sense_offset <= data[OFFSET_W-1:0];
				REG_SHORT_LIMIT:  cfg_q.short_limit  <= data[LIMIT_W-1:0];
				REG_OPEN_LIMIT:   cfg_q.open_limit   <= data[LIMIT_W-1:0];
				REG_IMB_PERCENT:  cfg_q.imb_percent  <= data[PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> src/wrc_lane.sv
// ----------------------------------------------------------------------------
// Winding resistance check line lane
// Computes one saturated line resistance from supply and duty.
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_lane
	import wrc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic [SUPPLY_BITS-1:0] supply,
	input  wire logic [DUTY_BITS-1:0]   duty,
	input  wire logic [GAIN_W-1:0]      line_gain,
	input  wire logic [OFFSET_W-1:0]    sense_offset,
	output logic signed [R_W-1:0]       line_r
);

	logic [SD_W-1:0]          sd_s1;
	logic [PROD_W-1:0]        prod_s2;
	logic signed [LV_W-1:0]   lv;
	logic signed [R_W-1:0]    line_s3;

	always_ff @(posedge clk) begin
		sd_s1   <= SD_W'(supply) * SD_W'(duty);
		prod_s2 <= PROD_W'(sd_s1) * PROD_W'(line_gain);
	end

	always_comb begin
		lv = $signed({1'b0, prod_s2[PROD_W-1:8]}) - $signed(LV_W'(sense_offset));
	end

	always_ff @(posedge clk) begin
		if (lv[LV_W-1:R_W-1] == '0 || lv[LV_W-1:R_W-1] == '1) begin
			line_s3 <= lv[R_W-1:0];
		end else begin
			line_s3 <= lv[LV_W-1] ? R_MIN : R_MAX;
		end
	end

	assign line_r = line_s3;

endmodule

`default_nettype wire

>>> src/wrc_merge.sv
// ----------------------------------------------------------------------------
// Winding resistance check merge stage
// Combines the three line values into phase values and the alarm code.
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_merge
	import wrc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ctl_t                    ctl_in,
	input  wire logic signed [R_W-1:0]   l12,
	input  wire logic signed [R_W-1:0]   l13,
	input  wire logic signed [R_W-1:0]   l23,
	input  wire logic [PCT_W-1:0]        imb_percent,
	output logic                         done,
	output logic signed [R_W-1:0]        phase_r1,
	output logic signed [R_W-1:0]        phase_r2,
	output logic signed [R_W-1:0]        phase_r3,
	output logic [1:0]                   alarm_code
);

	ctl_t ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic done_q;

	logic signed [R_W-1:0]   r_s4 [3];
	logic signed [R_W-1:0]   r_s5 [3];
	logic signed [R_W-1:0]   r_s6 [3];
	logic signed [R_W-1:0]   r_s7 [3];
	logic signed [R_W-1:0]   r_q  [3];
	logic signed [SUM_W-1:0] tr_s5 [3];
	logic signed [SUM_W-1:0] sum_s5;
	logic [D_W-1:0]          ad_s6 [3];
	logic [SUM_W-1:0]        as_s6;
	logic [LHS_W-1:0]        lhs_s7 [3];
	logic [RHS_W-1:0]        rhs_s7;
	logic [1:0]              alarm_q;

	logic signed [SUM_W-1:0] pair [3];
	logic signed [D_W-1:0]   dev [3];
	logic                    imb;
	alarm_t                  alarm_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s4 <= ctl_in;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			done_q <= ctl_s7.valid;
		end
	end

	always_comb begin
		pair[0] = SUM_W'(l12) + SUM_W'(l13) - SUM_W'(l23);
		pair[1] = SUM_W'(l12) + SUM_W'(l23) - SUM_W'(l13);
		pair[2] = SUM_W'(l13) + SUM_W'(l23) - SUM_W'(l12);
		for (int i = 0; i < 3; i++) begin
			dev[i] = D_W'(tr_s5[i]) - D_W'(sum_s5);
		end
		imb = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (lhs_s7[i] > LHS_W'(rhs_s7)) begin
				imb = 1'b1;
			end
		end
		if (ctl_s7.short_f) begin
			alarm_nx = ALARM_LOW_DUTY;
		end else if (ctl_s7.open_f) begin
			alarm_nx = ALARM_HIGH_DUTY;
		end else if (imb) begin
			alarm_nx = ALARM_IMBALANCE;
		end else begin
			alarm_nx = ALARM_NONE;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			r_s4[i]   <= sat_half(pair[i]);
			r_s5[i]   <= r_s4[i];
			tr_s5[i]  <= SUM_W'(r_s4[i]) + (SUM_W'(r_s4[i]) <<< 1);
			r_s6[i]   <= r_s5[i];
			ad_s6[i]  <= dev[i][D_W-1] ? D_W'(-dev[i]) : D_W'(dev[i]);
			r_s7[i]   <= r_s6[i];
			lhs_s7[i] <= LHS_W'(ad_s6[i]) * PCT_SCALE;
			r_q[i]    <= r_s7[i];
		end
		sum_s5  <= SUM_W'(r_s4[0]) + SUM_W'(r_s4[1]) + SUM_W'(r_s4[2]);
		as_s6   <= sum_s5[SUM_W-1] ? SUM_W'(-sum_s5) : SUM_W'(sum_s5);
		rhs_s7  <= RHS_W'(imb_percent) * RHS_W'(as_s6);
		alarm_q <= alarm_nx;
	end

	assign done       = done_q;
	assign phase_r1   = r_q[0];
	assign phase_r2   = r_q[1];
	assign phase_r3   = r_q[2];
	assign alarm_code = alarm_q;

endmodule

`default_nettype wire

>>> src/winding_resistance_check_core.sv
// A request accepted at a clock edge passes the lane registers and then the merge stage
// registers before its result shows with done. Throughput: one request per clock cycle;
// the three line lanes and the merge stage are fully pipelined, so start may stay high
// every cycle. Reset: arst_n clears the pipeline valids and loads the register defaults;
// busy stays high until run_q is set after reset is released. The receiver cannot stall.
// ----------------------------------------------------------------------------
// Winding resistance check core
// Three line lanes in parallel feeding a merge stage for phase values and alarm.
// ----------------------------------------------------------------------------
`default_nettype none

module winding_resistance_check_core
	import wrc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [SUPPLY_BITS-1:0] supply_sample,
	input  wire logic [DUTY_BITS-1:0]   duty_12,
	input  wire logic [DUTY_BITS-1:0]   duty_13,
	input  wire logic [DUTY_BITS-1:0]   duty_23,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                        done,
	output logic signed [R_W-1:0]       phase_r1,
	output logic signed [R_W-1:0]       phase_r2,
	output logic signed [R_W-1:0]       phase_r3,
	output logic [1:0]                  alarm_code
);

	cfg_t cfg;
	logic run_q;
	logic accept;
	logic short_nx, open_nx;
	ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [DUTY_BITS-1:0]   duty [3];
	logic signed [R_W-1:0]  line_r [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	assign busy      = !run_q;
	assign cfg_ready = run_q;
	assign accept    = start && run_q;

	wrc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_valid && cfg_ready),
		.idx    (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign duty[0] = duty_12;
	assign duty[1] = duty_13;
	assign duty[2] = duty_23;

	always_comb begin
		short_nx = 1'b0;
		open_nx  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (CMP_W'(duty[i]) < CMP_W'(cfg.short_limit)) begin
				short_nx = 1'b1;
			end
			if (CMP_W'(duty[i]) >= CMP_W'(cfg.open_limit)) begin
				open_nx = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1.valid   <= accept;
			ctl_s1.short_f <= short_nx;
			ctl_s1.open_f  <= open_nx;
			ctl_s2         <= ctl_s1;
			ctl_s3         <= ctl_s2;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		wrc_lane u_lane (
			.clk          (clk),
			.supply       (supply_sample),
			.duty         (duty[g]),
			.line_gain    (cfg.line_gain),
			.sense_offset (cfg.sense_offset),
			.line_r       (line_r[g])
		);
	end

	wrc_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_in      (ctl_s3),
		.l12         (line_r[0]),
		.l13         (line_r[1]),
		.l23         (line_r[2]),
		.imb_percent (cfg.imb_percent),
		.done        (done),
		.phase_r1    (phase_r1),
		.phase_r2    (phase_r2),
		.phase_r3    (phase_r3),
		.alarm_code  (alarm_code)
	);

endmodule

`default_nettype wire

>>> src/wrc_checker.sv
// ----------------------------------------------------------------------------
// Winding resistance check port checker
// Watches the top-level ports for request timing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "winding_resistance_check_core_defines.svh"

module wrc_checker
	import wrc_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire logic signed [R_W-1:0] phase_r1,
	input wire logic signed [R_W-1:0] phase_r2,
	input wire logic signed [R_W-1:0] phase_r3,
	input wire logic [1:0]            alarm_code
);

	`WRC_ASSERT_CLK(a_req_gives_result, (start && !busy) |-> ##8 done, "request without result")
	`WRC_ASSERT_CLK(a_result_has_req, done |-> $past(start && !busy, 8), "result without request")
	`WRC_ASSERT_NEVER(a_zero_no_imb, done && phase_r1 == '0 && phase_r2 == '0 && phase_r3 == '0 && alarm_code == ALARM_IMBALANCE, "imbalance on all-zero phases")

endmodule

bind winding_resistance_check_core wrc_checker u_wrc_checker (.*);

`default_nettype wire
